// ----- hw/rtl/lsbse_pkg.sv -----
// Shared types, codes and constants for the LSB stego payload extractor.
package lsbse_pkg;

	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned BYTE_BITS = 8;
	localparam int unsigned CNT_W     = $clog2(WORD_BITS);

	localparam logic [15:0] SKIP_RESET   = 16'd54;
	localparam logic [7:0]  MAGIC1_RESET = 8'd35;
	localparam logic [7:0]  MAGIC2_RESET = 8'd42;

	// Configuration register indexes
	localparam logic [1:0] CFG_HEADER_SKIP  = 2'd0;
	localparam logic [1:0] CFG_MAGIC_FIRST  = 2'd1;
	localparam logic [1:0] CFG_MAGIC_SECOND = 2'd2;

	// Result kinds
	localparam logic [2:0] K_MISMATCH = 3'd0;
	localparam logic [2:0] K_EXT_LEN  = 3'd1;
	localparam logic [2:0] K_EXT_CHAR = 3'd2;
	localparam logic [2:0] K_SIZE     = 3'd3;
	localparam logic [2:0] K_PAYLOAD  = 3'd4;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_MAGIC,
		PH_EXT_LEN,
		PH_EXT_CHAR,
		PH_SIZE,
		PH_PAYLOAD,
		PH_STOPPED
	} phase_t;

	typedef struct packed {
		logic [7:0] image_byte;
		logic       new_image;
	} img_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [15:0] header_skip;
		logic [7:0]  magic_first;
		logic [7:0]  magic_second;
	} cfg_t;

endpackage

// ----- hw/rtl/lsbse_cfg_regs.sv -----
// Configuration register file of the stego extractor.
module lsbse_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output lsbse_pkg::cfg_t   cfg
);
	import lsbse_pkg::*;

	cfg_t cfg_q;

	// Always take a write request; unknown indexes are dropped
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_skip  <= SKIP_RESET;
			cfg_q.magic_first  <= MAGIC1_RESET;
			cfg_q.magic_second <= MAGIC2_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HEADER_SKIP:  cfg_q.header_skip  <= cfg_data;
				CFG_MAGIC_FIRST:  cfg_q.magic_first  <= cfg_data[7:0];
				CFG_MAGIC_SECOND: cfg_q.magic_second <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- hw/rtl/lsbse_parser.sv -----
// Parse state machine: header skip, bit collector and field decoding.
module lsbse_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  lsbse_pkg::img_t   img,
	input  lsbse_pkg::cfg_t   cfg,
	output logic              hit,
	output lsbse_pkg::res_t   res
);
	import lsbse_pkg::*;

	phase_t             phase_q, phase_d;
	logic [15:0]        header_count_q, header_count_d;
	logic [CNT_W-1:0]   bit_count_q, bit_count_d;
	logic [WORD_BITS-1:0] shift_word_q, shift_word_d;
	logic [WORD_BITS-1:0] remaining_q, remaining_d;
	logic               magic_index_q, magic_index_d;

	// Effective state after an optional restart
	phase_t               ph;
	phase_t               wp;
	logic [15:0]          hc;
	logic [CNT_W-1:0]     bc;
	logic [WORD_BITS-1:0] sw;
	logic [WORD_BITS-1:0] rem;
	logic                 mi;
	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] rem_dec;
	logic [CNT_W:0]       need;
	logic                 done;
	logic [7:0]           magic_exp;

	assign ph  = img.new_image ? PH_HEADER : phase_q;
	assign hc  = img.new_image ? 16'd0 : header_count_q;
	assign bc  = img.new_image ? '0 : bit_count_q;
	assign sw  = img.new_image ? '0 : shift_word_q;
	assign rem = img.new_image ? '0 : remaining_q;
	assign mi  = img.new_image ? 1'b0 : magic_index_q;

	// Header end falls through to the magic phase on the same byte
	assign wp = (ph == PH_HEADER && hc >= cfg.header_skip) ? PH_MAGIC : ph;

	// Collect one bit, LSB first
	assign need = (wp == PH_EXT_LEN || wp == PH_SIZE) ? (CNT_W+1)'(WORD_BITS)
	                                                  : (CNT_W+1)'(BYTE_BITS);
	assign word      = sw | (WORD_BITS'(img.image_byte[0]) << bc);
	assign done      = ({1'b0, bc} + 1'b1) >= need;
	assign rem_dec   = rem - 1'b1;
	assign magic_exp = mi ? cfg.magic_second : cfg.magic_first;

	// Next state
	always_comb begin
		phase_d        = wp;
		header_count_d = hc;
		bit_count_d    = bc;
		shift_word_d   = sw;
		remaining_d    = rem;
		magic_index_d  = mi;
		if (wp == PH_MAGIC || wp == PH_EXT_LEN || wp == PH_EXT_CHAR ||
		    wp == PH_SIZE || wp == PH_PAYLOAD) begin
			if (done) begin
				bit_count_d  = '0;
				shift_word_d = '0;
			end else begin
				bit_count_d  = bc + 1'b1;
				shift_word_d = word;
			end
		end
		case (wp)
			PH_HEADER: begin
				header_count_d = hc + 1'b1;
			end
			PH_MAGIC: begin
				if (done) begin
					if (word[7:0] != magic_exp) begin
						phase_d = PH_STOPPED;
					end else if (mi) begin
						magic_index_d = 1'b0;
						phase_d       = PH_EXT_LEN;
					end else begin
						magic_index_d = 1'b1;
					end
				end
			end
			PH_EXT_LEN: begin
				if (done) begin
					remaining_d = word;
					phase_d     = (word == '0) ? PH_SIZE : PH_EXT_CHAR;
				end
			end
			PH_EXT_CHAR: begin
				if (done) begin
					remaining_d = rem_dec;
					if (rem_dec == '0) phase_d = PH_SIZE;
				end
			end
			PH_SIZE: begin
				if (done) begin
					remaining_d = word;
					phase_d     = (word == '0) ? PH_STOPPED : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (done) begin
					remaining_d = rem_dec;
					if (rem_dec == '0) phase_d = PH_STOPPED;
				end
			end
			default: ;
		endcase
	end

	// Result decode
	always_comb begin
		hit       = 1'b0;
		res.kind  = K_MISMATCH;
		res.value = '0;
		res.last  = 1'b0;
		case (wp)
			PH_MAGIC: begin
				if (done && word[7:0] != magic_exp) begin
					hit      = 1'b1;
					res.last = 1'b1;
				end
			end
			PH_EXT_LEN: begin
				hit       = done;
				res.kind  = K_EXT_LEN;
				res.value = word;
			end
			PH_EXT_CHAR: begin
				hit       = done;
				res.kind  = K_EXT_CHAR;
				res.value = word;
			end
			PH_SIZE: begin
				hit       = done;
				res.kind  = K_SIZE;
				res.value = word;
				res.last  = (word == '0);
			end
			PH_PAYLOAD: begin
				hit       = done;
				res.kind  = K_PAYLOAD;
				res.value = word;
				res.last  = (rem_dec == '0);
			end
			default: ;
		endcase
	end

	// Advance state on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			header_count_q <= '0;
			bit_count_q    <= '0;
			shift_word_q   <= '0;
			remaining_q    <= '0;
			magic_index_q  <= 1'b0;
		end else if (step) begin
			phase_q        <= phase_d;
			header_count_q <= header_count_d;
			bit_count_q    <= bit_count_d;
			shift_word_q   <= shift_word_d;
			remaining_q    <= remaining_d;
			magic_index_q  <= magic_index_d;
		end
	end

	// Byte-wide items never hold more than seven pending bits
	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_MAGIC || phase_q == PH_EXT_CHAR || phase_q == PH_PAYLOAD)
		|-> (bit_count_q < CNT_W'(BYTE_BITS)))
		else $error("bit count overran a byte item");

	// A stopped parser stays silent until a new image
	a_stopped_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_STOPPED && !img.new_image) |-> !hit)
		else $error("result produced while stopped");

	// Character and payload phases always have something left to deliver
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EXT_CHAR || phase_q == PH_PAYLOAD) |-> (remaining_q != '0))
		else $error("empty count in a data phase");

endmodule

// ----- hw/rtl/lsb_stego_payload_extractor_unit.sv -----
// Top level of the LSB stego payload extractor: input register, parser, result register.
// Flow: a request is held in the input register at acceptance and is parsed once the result
//   register can take its outcome; the parser's result is then captured in the result register.
// Throughput: one image byte per cycle while the result register is not blocked by res_stall.
// Reset (arst_n low): parser restarts at header skip, registers return to
//   header_skip 54, magic 35 and 42, and both stage valids clear.
module lsb_stego_payload_extractor_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              img_valid,
	output logic              img_stall,
	input  lsbse_pkg::img_t   img,
	output logic              res_valid,
	input  logic              res_stall,
	output lsbse_pkg::res_t   res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import lsbse_pkg::*;

	cfg_t  cfg;
	img_t  img_s1;
	logic  valid_s1;
	res_t  res_q;
	res_t  res_d;
	logic  res_valid_q;
	logic  hit;
	logic  out_free;
	logic  step;

	lsbse_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Process the held byte whenever the result register can take its outcome
	assign out_free  = !res_valid_q || !res_stall;
	assign step      = valid_s1 && out_free;
	assign img_stall = valid_s1 && !out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (img_valid && !img_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (img_valid && !img_stall) begin
			img_s1 <= img;
		end
	end

	lsbse_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.img    (img_s1),
		.cfg    (cfg),
		.hit    (hit),
		.res    (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= step && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && hit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A mismatch report always closes the stream with a zero value
	a_mismatch_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == K_MISMATCH) |-> (res.last && res.value == '0))
		else $error("malformed mismatch result");

	// Input stalls only while a byte waits behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		img_stall |-> (valid_s1 && res_valid_q && res_stall))
		else $error("input stalled without a blocked result");

	// A blocked result is never overwritten
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |=> (res_valid_q && $stable(res_q)))
		else $error("blocked result changed");

endmodule
